/* rtl/wavp_pkg.sv */
package wavp_pkg;

  // Chunk tags, as they sit in the byte history with the first byte highest
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Fixed header offsets
  localparam logic [31:0] OFF_RIFF_END  = 32'd3;
  localparam logic [31:0] OFF_WAVE_END  = 32'd11;
  localparam logic [31:0] OFF_FMT_END   = 32'd15;
  localparam logic [31:0] OFF_FMT_CODE  = 32'd21;
  localparam logic [31:0] OFF_CHANNELS  = 32'd23;
  localparam logic [31:0] OFF_RATE_END  = 32'd27;
  localparam logic [31:0] OFF_BITS      = 32'd35;
  localparam logic [31:0] MIN_HDR_LAST  = 32'd43;
  localparam logic [31:0] FIRST_CHUNK   = 32'd12;
  localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;

  localparam logic [15:0] PCM_FORMAT = 16'd1;

  typedef struct packed {
    logic        header_ok;
    logic [31:0] sample_rate;
    logic [1:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [31:0] payload_start;
    logic [31:0] payload_bytes;
    logic [31:0] frame_total;
  } wavp_result_t;

endpackage

/* rtl/wavp_core.sv */
module wavp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  res_valid,
  output wavp_pkg::wavp_result_t res
);
  import wavp_pkg::*;

  logic [31:0] byte_offset, byte_offset_next;
  logic [31:0] next_chunk_at, next_chunk_at_next;
  logic [63:0] recent_bytes, recent_bytes_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [1:0]  channels_reg, channels_reg_next;
  logic [4:0]  bits_reg, bits_reg_next;
  logic        result_given, result_given_next;
  logic        data_found, data_found_next;
  logic [31:0] found_size, found_size_next;
  logic [31:0] found_start, found_start_next;

  logic [31:0] le32_now;
  logic [15:0] le16_now;
  logic        fail;
  logic        chunk_hit;
  logic        ok_now;
  logic [1:0]  frame_shift;

  // Little-endian views of the newest bytes
  always_comb begin
    recent_bytes_next = {recent_bytes[55:0], data_byte};
    le32_now = {recent_bytes_next[7:0], recent_bytes_next[15:8],
                recent_bytes_next[23:16], recent_bytes_next[31:24]};
    le16_now = {recent_bytes_next[7:0], recent_bytes_next[15:8]};
  end

  // Fixed-offset checks and captures, chunk walk, result decision
  always_comb begin
    fail               = 1'b0;
    rate_reg_next      = rate_reg;
    channels_reg_next  = channels_reg;
    bits_reg_next      = bits_reg;
    data_found_next    = data_found;
    found_size_next    = found_size;
    found_start_next   = found_start;
    next_chunk_at_next = next_chunk_at;

    case (byte_offset)
      OFF_RIFF_END: fail = recent_bytes_next[31:0] != TAG_RIFF;
      OFF_WAVE_END: fail = recent_bytes_next[31:0] != TAG_WAVE;
      OFF_FMT_END:  fail = recent_bytes_next[31:0] != TAG_FMT;
      OFF_FMT_CODE: fail = le16_now != PCM_FORMAT;
      OFF_CHANNELS: begin
        channels_reg_next = le16_now[1:0];
        fail = (le16_now != 16'd1) && (le16_now != 16'd2);
      end
      OFF_RATE_END: rate_reg_next = le32_now;
      OFF_BITS: begin
        bits_reg_next = le16_now[4:0];
        fail = (le16_now != 16'd8) && (le16_now != 16'd16);
      end
      default: fail = 1'b0;
    endcase

    chunk_hit = !data_found && (byte_offset == next_chunk_at + 32'd7);
    if (chunk_hit) begin
      if (recent_bytes_next[63:32] == TAG_DATA) begin
        data_found_next  = 1'b1;
        found_start_next = next_chunk_at + CHUNK_HDR_LEN;
        found_size_next  = le32_now;
      end else begin
        next_chunk_at_next = next_chunk_at + CHUNK_HDR_LEN + le32_now;
      end
    end

    ok_now    = !fail && data_found_next && (byte_offset >= MIN_HDR_LAST);
    res_valid = step && !result_given && (fail || ok_now || last_byte);

    frame_shift = {1'b0, channels_reg_next == 2'd2} + {1'b0, bits_reg_next == 5'd16};
    res = '0;
    if (ok_now) begin
      res.header_ok     = 1'b1;
      res.sample_rate   = rate_reg_next;
      res.channel_count = channels_reg_next;
      res.sample_bits   = bits_reg_next;
      res.payload_start = found_start_next;
      res.payload_bytes = found_size_next;
      res.frame_total   = found_size_next >> frame_shift;
    end

    byte_offset_next  = byte_offset + 32'd1;
    result_given_next = result_given || res_valid;
  end

  // Advance state per word; the final word restarts the parser
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_offset   <= '0;
      next_chunk_at <= FIRST_CHUNK;
      recent_bytes  <= '0;
      rate_reg      <= '0;
      channels_reg  <= '0;
      bits_reg      <= '0;
      result_given  <= 1'b0;
      data_found    <= 1'b0;
      found_size    <= '0;
      found_start   <= '0;
    end else if (step && !result_given) begin
      byte_offset   <= byte_offset_next;
      next_chunk_at <= next_chunk_at_next;
      recent_bytes  <= recent_bytes_next;
      rate_reg      <= rate_reg_next;
      channels_reg  <= channels_reg_next;
      bits_reg      <= bits_reg_next;
      result_given  <= result_given_next;
      data_found    <= data_found_next;
      found_size    <= found_size_next;
      found_start   <= found_start_next;
    end
  end

endmodule

/* rtl/wav_header_parser.sv */
// WAV header parser.
// Input channel: in_valid/in_ready carry one buffer byte per word (data_byte),
// in order from offset zero, with last_byte set on the final byte.
// Output channel: out_valid/out_ready carry one result word per buffer:
// header_ok and the captured format fields on success, all zero on failure.
// A result is given on the byte that fails a check, on the first byte at
// which the data chunk header is complete with at least 44 bytes seen, or
// on the final byte if neither happened first. Bytes after the result are
// dropped; the final byte restarts the parser for the next buffer.
// Throughput: one byte per cycle while no result waits for out_ready. Path: a
// byte lands in the input register, then the result register loads its result
// and raises out_valid, through the single compare/add stage between them.
// Reset: rst (synchronous, active high) clears both stages and the parser.
// Stall: while a result waits for out_ready, the input register holds one
// byte and in_ready drops once it is full; nothing is lost.
module wav_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        header_ok,
  output logic [31:0] sample_rate,
  output logic [1:0]  channel_count,
  output logic [4:0]  sample_bits,
  output logic [31:0] payload_start,
  output logic [31:0] payload_bytes,
  output logic [31:0] frame_total
);
  import wavp_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         advance;
  logic         res_valid;
  wavp_result_t res;
  wavp_result_t out_res;

  // Stage 1 moves on when the result register is free or being drained
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Hold the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  wavp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign header_ok     = out_res.header_ok;
  assign sample_rate   = out_res.sample_rate;
  assign channel_count = out_res.channel_count;
  assign sample_bits   = out_res.sample_bits;
  assign payload_start = out_res.payload_start;
  assign payload_bytes = out_res.payload_bytes;
  assign frame_total   = out_res.frame_total;

endmodule
